// File: sv/rdq_pkg.sv
package rdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_PUSH_END,
    OP_SHIFT_DOWN,
    OP_ROT_DOWN,
    OP_ROT_UP
  } cell_op_t;

endpackage

// File: sv/rdq_cell.sv
module rdq_cell
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic [CW-1:0]            count,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic signed [WORD_W-1:0] lower_q,
  input  logic signed [WORD_W-1:0] upper_q,
  input  logic signed [WORD_W-1:0] head_q,
  input  logic signed [WORD_W-1:0] tail_q,
  output logic signed [WORD_W-1:0] data_q,
  output logic signed [WORD_W-1:0] tail_part
);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic                     is_end;
  logic                     is_tail;
  logic                     below_tail;
  logic                     in_use;

  assign is_end     = (count == CW'(IDX));
  assign is_tail    = (count == CW'(IDX + 1));
  assign below_tail = (CW'(IDX + 1) < count);
  assign in_use     = (CW'(IDX) < count);

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      OP_HOLD: ;
      OP_SHIFT_UP: begin
        data_nxt = (IDX == 0) ? in_value : lower_q;
      end
      OP_PUSH_END: begin
        if (is_end) data_nxt = in_value;
      end
      OP_SHIFT_DOWN: begin
        data_nxt = upper_q;
      end
      OP_ROT_DOWN: begin
        if (is_tail) data_nxt = head_q;
        else if (below_tail) data_nxt = upper_q;
      end
      OP_ROT_UP: begin
        if (IDX == 0) data_nxt = tail_q;
        else if (in_use) data_nxt = lower_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q    = data_r;
  assign tail_part = is_tail ? data_r : '0;

endmodule

// File: sv/reversible_deque.sv
// Results are registered: the result strobe comes in the cycle after the command is accepted.
// Push, pop and reverse: one item per cycle, back to back outside a dump; busy stays low.
// Dump of N entries: N results back to back, busy high from the accepting edge
// until the last result is registered, while the cell row rotates by one entry per cycle.
// Reset (rst_n low, synchronous): queue empty, order normal, no result.
// The receiver cannot stall; each result transfers in its strobe cycle.
module reversible_deque
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic                     out_last
);

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            left_r, left_nxt;
  logic                     rev_r, rev_nxt;
  logic                     valid_r, valid_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic                     last_r, last_nxt;

  cell_op_t                 op;
  logic                     accept;
  logic                     at_start;
  logic signed [WORD_W-1:0] head_bus;
  logic signed [WORD_W-1:0] tail_bus;
  logic signed [WORD_W-1:0] cell_q    [DEPTH];
  logic signed [WORD_W-1:0] tail_part [DEPTH];

  assign busy     = (left_r != '0);
  assign accept   = start && !busy;
  assign head_bus = cell_q[0];

  always_comb begin
    tail_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_bus = tail_bus | tail_part[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] lower_q;
    logic signed [WORD_W-1:0] upper_q;
    if (g == 0) begin : g_first
      assign lower_q = cell_q[g];
    end else begin : g_lower
      assign lower_q = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper_q = cell_q[g];
    end else begin : g_upper
      assign upper_q = cell_q[g+1];
    end
    rdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count_r),
      .in_value  (in_value),
      .lower_q   (lower_q),
      .upper_q   (upper_q),
      .head_q    (head_bus),
      .tail_q    (tail_bus),
      .data_q    (cell_q[g]),
      .tail_part (tail_part[g])
    );
  end

  always_comb begin
    op         = OP_HOLD;
    count_nxt  = count_r;
    left_nxt   = left_r;
    rev_nxt    = rev_r;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    value_nxt  = '0;
    last_nxt   = 1'b1;
    at_start   = ((in_command == CMD_PUSH_FRONT) || (in_command == CMD_POP_FRONT)) ^ rev_r;
    if (busy) begin
      op        = rev_r ? OP_ROT_UP : OP_ROT_DOWN;
      valid_nxt = 1'b1;
      value_nxt = rev_r ? tail_bus : head_bus;
      last_nxt  = (left_r == CW'(1));
      left_nxt  = left_r - CW'(1);
    end else if (accept) begin
      unique case (in_command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          valid_nxt = 1'b1;
          if (count_r == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            op        = at_start ? OP_SHIFT_UP : OP_PUSH_END;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          valid_nxt = 1'b1;
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            op        = at_start ? OP_SHIFT_DOWN : OP_HOLD;
            value_nxt = at_start ? head_bus : tail_bus;
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_REVERSE: begin
          valid_nxt = 1'b1;
          if (count_r == '0) status_nxt = ST_EMPTY;
          else rev_nxt = !rev_r;
        end
        CMD_DUMP: begin
          valid_nxt = 1'b1;
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            op        = rev_r ? OP_ROT_UP : OP_ROT_DOWN;
            value_nxt = rev_r ? tail_bus : head_bus;
            last_nxt  = (count_r == CW'(1));
            left_nxt  = count_r - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      left_r  <= '0;
      rev_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      left_r  <= left_nxt;
      rev_r   <= rev_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_last      = last_r;

  a_left_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (left_r < count_r))
    else $error("dump countdown exceeds entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("dump cycle without a result");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_last && (out_value_out == '0)))
    else $error("error result not final or carries data");

  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && (left_r == CW'(1))) |=> (out_valid && out_last && !busy))
    else $error("dump does not end with last");

endmodule
